// ===== rtl/tlpte_pkg.sv =====
package tlpte_pkg;

    localparam int DIR_ENTRIES_DEF   = 1024;
    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int VA_W    = 32;
    localparam int FRAME_W = 20;
    localparam int OFS_W   = 12;

    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_MAP       = 2'd1;
    localparam logic [1:0] CMD_UNMAP     = 2'd2;

    localparam logic [OFS_W-1:0] PG_PRESENT = 12'h001;
    localparam logic [OFS_W-1:0] PG_WRITE   = 12'h002;
    localparam logic [OFS_W-1:0] PG_ALLOC   = 12'h200;
    localparam int               ALLOC_BIT  = 9;

    typedef enum logic [2:0] {
        ST_CLR_DIR,
        ST_IDLE,
        ST_DIR_CHK,
        ST_CLR_TBL,
        ST_TBL_CHK,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic dir_rd;
        logic dir_clr_wr;
        logic dir_new_wr;
        logic tbl_rd;
        logic tbl_clr_wr;
        logic finish;
        logic out_load;
        logic cnt_inc;
        logic cnt_clr;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       dir_nz;
        logic       dir_last;
        logic       tbl_last;
        logic       out_free;
    } sts_t;

endpackage

// ===== rtl/two_level_page_table_engine_core.sv =====
// Channel   Direction  Ports                                          Handshake
// request   in         s_cmd s_virt_addr s_phys_in s_page_flags       s_valid / s_ready
//                      s_table_frame s_page_frame
// result    out        m_phys_out m_mapped m_freed_valid m_freed_frame m_valid / m_ready
//                      m_table_frame_taken m_page_frame_taken
//
// One word at a time. A word that reads its table goes through directory read, table read,
// entry update and output load before the next accept; a translate or unmap on an empty
// directory slot, or an unused command, skips the table read and the entry update. A map that
// creates a table writes the directory entry and sweeps the new table clear before its update.
// After reset the directory is cleared one entry a cycle with s_ready low. A stalled result
// holds in the output register; the next word is still taken and waits in the final state
// until that register frees up.
module two_level_page_table_engine_core #(
    parameter int DIR_ENTRIES   = tlpte_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tlpte_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [tlpte_pkg::VA_W-1:0]    s_virt_addr,
    input  logic [tlpte_pkg::VA_W-1:0]    s_phys_in,
    input  logic [tlpte_pkg::OFS_W-1:0]   s_page_flags,
    input  logic [tlpte_pkg::FRAME_W-1:0] s_table_frame,
    input  logic [tlpte_pkg::FRAME_W-1:0] s_page_frame,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tlpte_pkg::VA_W-1:0]    m_phys_out,
    output logic                          m_mapped,
    output logic                          m_freed_valid,
    output logic [tlpte_pkg::FRAME_W-1:0] m_freed_frame,
    output logic                          m_table_frame_taken,
    output logic                          m_page_frame_taken
);

    // command and status between sequencer and datapath
    tlpte_pkg::ctl_t ctl;
    tlpte_pkg::sts_t sts;

    // sequence the directory clear after reset, then each word: read directory, read or clear table, update, load
    tlpte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // hold both memories, the captured word, the sweep counter and the output register
    tlpte_datapath #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .ctl                 (ctl),
        .sts                 (sts),
        .s_cmd               (s_cmd),
        .s_virt_addr         (s_virt_addr),
        .s_phys_in           (s_phys_in),
        .s_page_flags        (s_page_flags),
        .s_table_frame       (s_table_frame),
        .s_page_frame        (s_page_frame),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_phys_out          (m_phys_out),
        .m_mapped            (m_mapped),
        .m_freed_valid       (m_freed_valid),
        .m_freed_frame       (m_freed_frame),
        .m_table_frame_taken (m_table_frame_taken),
        .m_page_frame_taken  (m_page_frame_taken)
    );

endmodule

// ===== rtl/tlpte_ram.sv =====
module tlpte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic [AW-1:0]    addr,
    input  logic             we,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tlpte_datapath.sv =====
module tlpte_datapath #(
    parameter int DIR_ENTRIES   = tlpte_pkg::DIR_ENTRIES_DEF,
    parameter int TABLE_ENTRIES = tlpte_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tlpte_pkg::ctl_t              ctl,
    output tlpte_pkg::sts_t              sts,
    input  logic [1:0]                   s_cmd,
    input  logic [tlpte_pkg::VA_W-1:0]   s_virt_addr,
    input  logic [tlpte_pkg::VA_W-1:0]   s_phys_in,
    input  logic [tlpte_pkg::OFS_W-1:0]  s_page_flags,
    input  logic [tlpte_pkg::FRAME_W-1:0] s_table_frame,
    input  logic [tlpte_pkg::FRAME_W-1:0] s_page_frame,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tlpte_pkg::VA_W-1:0]   m_phys_out,
    output logic                         m_mapped,
    output logic                         m_freed_valid,
    output logic [tlpte_pkg::FRAME_W-1:0] m_freed_frame,
    output logic                         m_table_frame_taken,
    output logic                         m_page_frame_taken
);

    localparam int VA_W    = tlpte_pkg::VA_W;
    localparam int FRAME_W = tlpte_pkg::FRAME_W;
    localparam int OFS_W   = tlpte_pkg::OFS_W;
    localparam int DIR_W   = $clog2(DIR_ENTRIES);
    localparam int TBL_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = (DIR_W > TBL_W) ? DIR_W : TBL_W;
    localparam int TA_W    = DIR_W + TBL_W;

    // captured word
    logic [1:0]         cmd_reg;
    logic [VA_W-1:0]    va_reg;
    logic [VA_W-1:0]    pa_reg;
    logic [OFS_W-1:0]   flags_reg;
    logic [FRAME_W-1:0] tframe_reg;
    logic [FRAME_W-1:0] pframe_reg;
    logic               e_zero_reg;

    // sweep counter
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    // pending result
    logic [VA_W-1:0]    res_phys_reg;
    logic               res_mapped_reg;
    logic               res_fvalid_reg;
    logic [FRAME_W-1:0] res_fframe_reg;
    logic               res_ttaken_reg;
    logic               res_ptaken_reg;

    // output word
    logic               m_valid_reg;
    logic [VA_W-1:0]    m_phys_reg;
    logic               m_mapped_reg;
    logic               m_fvalid_reg;
    logic [FRAME_W-1:0] m_fframe_reg;
    logic               m_ttaken_reg;
    logic               m_ptaken_reg;

    logic [DIR_W-1:0]   s_di;
    logic [DIR_W-1:0]   di;
    logic [TBL_W-1:0]   ti;

    logic [DIR_W-1:0]   dir_addr;
    logic               dir_we;
    logic [VA_W-1:0]    dir_wdata;
    logic [VA_W-1:0]    dir_rdata;
    logic [TA_W-1:0]    tbl_addr;
    logic               tbl_we;
    logic [VA_W-1:0]    tbl_wdata;
    logic [VA_W-1:0]    tbl_rdata;

    logic [VA_W-1:0]    ent;
    logic               ent_alloc;
    logic               upd_wr;
    logic [VA_W-1:0]    upd_data;
    logic [VA_W-1:0]    phys_c;
    logic               mapped_c;
    logic               fvalid_c;
    logic [FRAME_W-1:0] fframe_c;
    logic               ptaken_c;

    assign s_di = s_virt_addr[VA_W-1 -: DIR_W];
    assign di   = va_reg[VA_W-1 -: DIR_W];
    assign ti   = va_reg[VA_W-1-DIR_W -: TBL_W];

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.cnt_clr) begin
            cnt_next = '0;
        end else if (ctl.cnt_inc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // directory memory
    assign dir_we    = ctl.dir_clr_wr | ctl.dir_new_wr;
    assign dir_addr  = ctl.dir_clr_wr ? cnt_reg[DIR_W-1:0] : (ctl.dir_rd ? s_di : di);
    assign dir_wdata = ctl.dir_clr_wr ? '0
                     : {tframe_reg, flags_reg | tlpte_pkg::PG_PRESENT | tlpte_pkg::PG_WRITE};

    tlpte_ram #(
        .WIDTH (VA_W),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .aclk  (aclk),
        .addr  (dir_addr),
        .we    (dir_we),
        .wdata (dir_wdata),
        .re    (ctl.dir_rd),
        .rdata (dir_rdata)
    );

    // entry update
    assign ent       = e_zero_reg ? '0 : tbl_rdata;
    assign ent_alloc = ent[tlpte_pkg::ALLOC_BIT];

    always_comb begin
        upd_wr   = 1'b0;
        upd_data = '0;
        phys_c   = '0;
        mapped_c = 1'b0;
        fvalid_c = 1'b0;
        fframe_c = '0;
        ptaken_c = 1'b0;
        unique case (cmd_reg)
            tlpte_pkg::CMD_TRANSLATE: begin
                if (ent != '0) begin
                    phys_c   = {ent[VA_W-1:OFS_W], va_reg[OFS_W-1:0]};
                    mapped_c = 1'b1;
                end
            end
            tlpte_pkg::CMD_MAP: begin
                if (pa_reg == '0) begin
                    if (!ent_alloc) begin
                        upd_wr   = 1'b1;
                        upd_data = {pframe_reg, flags_reg | tlpte_pkg::PG_PRESENT
                                    | tlpte_pkg::PG_ALLOC};
                        ptaken_c = 1'b1;
                    end
                end else begin
                    fvalid_c = ent_alloc;
                    fframe_c = ent_alloc ? ent[VA_W-1:OFS_W] : '0;
                    upd_wr   = 1'b1;
                    upd_data = {pa_reg[VA_W-1:OFS_W], flags_reg | tlpte_pkg::PG_PRESENT};
                end
            end
            tlpte_pkg::CMD_UNMAP: begin
                fvalid_c = ent_alloc;
                fframe_c = ent_alloc ? ent[VA_W-1:OFS_W] : '0;
                upd_wr   = 1'b1;
                upd_data = '0;
            end
            default: begin
            end
        endcase
    end

    // table memory
    assign tbl_we    = ctl.tbl_clr_wr | (ctl.finish & upd_wr);
    assign tbl_addr  = ctl.tbl_clr_wr ? {di, cnt_reg[TBL_W-1:0]} : {di, ti};
    assign tbl_wdata = ctl.tbl_clr_wr ? '0 : upd_data;

    tlpte_ram #(
        .WIDTH (VA_W),
        .DEPTH (DIR_ENTRIES * TABLE_ENTRIES)
    ) u_tbl_ram (
        .aclk  (aclk),
        .addr  (tbl_addr),
        .we    (tbl_we),
        .wdata (tbl_wdata),
        .re    (ctl.tbl_rd),
        .rdata (tbl_rdata)
    );

    // capture and result registers
    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg    <= s_cmd;
            va_reg     <= s_virt_addr;
            pa_reg     <= s_phys_in;
            flags_reg  <= s_page_flags;
            tframe_reg <= s_table_frame;
            pframe_reg <= s_page_frame;
            e_zero_reg <= 1'b0;
        end else if (ctl.dir_new_wr) begin
            e_zero_reg <= 1'b1;
        end

        if (ctl.load_in) begin
            res_phys_reg   <= '0;
            res_mapped_reg <= 1'b0;
            res_fvalid_reg <= 1'b0;
            res_fframe_reg <= '0;
            res_ttaken_reg <= 1'b0;
            res_ptaken_reg <= 1'b0;
        end else begin
            if (ctl.dir_new_wr) begin
                res_ttaken_reg <= 1'b1;
            end
            if (ctl.finish) begin
                res_phys_reg   <= phys_c;
                res_mapped_reg <= mapped_c;
                res_fvalid_reg <= fvalid_c;
                res_fframe_reg <= fframe_c;
                res_ptaken_reg <= ptaken_c;
            end
        end

        if (ctl.out_load) begin
            m_phys_reg   <= res_phys_reg;
            m_mapped_reg <= res_mapped_reg;
            m_fvalid_reg <= res_fvalid_reg;
            m_fframe_reg <= res_fframe_reg;
            m_ttaken_reg <= res_ttaken_reg;
            m_ptaken_reg <= res_ptaken_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.cmd      = cmd_reg;
    assign sts.dir_nz   = (dir_rdata != '0);
    assign sts.dir_last = (cnt_reg == CNT_W'(DIR_ENTRIES - 1));
    assign sts.tbl_last = (cnt_reg == CNT_W'(TABLE_ENTRIES - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid             = m_valid_reg;
    assign m_phys_out          = m_phys_reg;
    assign m_mapped            = m_mapped_reg;
    assign m_freed_valid       = m_fvalid_reg;
    assign m_freed_frame       = m_fframe_reg;
    assign m_table_frame_taken = m_ttaken_reg;
    assign m_page_frame_taken  = m_ptaken_reg;

endmodule

// ===== rtl/tlpte_ctrl.sv =====
module tlpte_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tlpte_pkg::sts_t sts,
    output tlpte_pkg::ctl_t ctl
);

    tlpte_pkg::state_t state_reg;
    tlpte_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlpte_pkg::ST_CLR_DIR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            tlpte_pkg::ST_CLR_DIR: begin
                ctl.dir_clr_wr = 1'b1;
                ctl.cnt_inc    = 1'b1;
                if (sts.dir_last) begin
                    ctl.cnt_clr = 1'b1;
                    state_next  = tlpte_pkg::ST_IDLE;
                end
            end
            tlpte_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load_in = 1'b1;
                    ctl.dir_rd  = 1'b1;
                    state_next  = tlpte_pkg::ST_DIR_CHK;
                end
            end
            tlpte_pkg::ST_DIR_CHK: begin
                priority if (sts.cmd == tlpte_pkg::CMD_MAP && !sts.dir_nz) begin
                    ctl.dir_new_wr = 1'b1;
                    ctl.cnt_clr    = 1'b1;
                    state_next     = tlpte_pkg::ST_CLR_TBL;
                end else if ((sts.cmd == tlpte_pkg::CMD_TRANSLATE
                              || sts.cmd == tlpte_pkg::CMD_MAP
                              || sts.cmd == tlpte_pkg::CMD_UNMAP) && sts.dir_nz) begin
                    ctl.tbl_rd = 1'b1;
                    state_next = tlpte_pkg::ST_TBL_CHK;
                end else begin
                    state_next = tlpte_pkg::ST_DONE;
                end
            end
            tlpte_pkg::ST_CLR_TBL: begin
                ctl.tbl_clr_wr = 1'b1;
                ctl.cnt_inc    = 1'b1;
                if (sts.tbl_last) begin
                    ctl.cnt_clr = 1'b1;
                    state_next  = tlpte_pkg::ST_TBL_CHK;
                end
            end
            tlpte_pkg::ST_TBL_CHK: begin
                ctl.finish = 1'b1;
                state_next = tlpte_pkg::ST_DONE;
            end
            tlpte_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = tlpte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlpte_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tlpte_checker.sv =====
module tlpte_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [tlpte_pkg::VA_W-1:0]    m_phys_out,
    input logic                          m_mapped,
    input logic                          m_freed_valid,
    input logic [tlpte_pkg::FRAME_W-1:0] m_freed_frame,
    input logic                          m_table_frame_taken,
    input logic                          m_page_frame_taken
);

    // one word in flight: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("word accepted while previous word in work");

    // a translate hit carries no free or take flags
    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mapped |-> !m_freed_valid && !m_table_frame_taken
                                && !m_page_frame_taken)
        else $error("translate result with map or unmap flags");

    // no freed frame number without the freed flag
    a_freed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_freed_valid |-> m_freed_frame == '0)
        else $error("freed frame nonzero without freed flag");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_phys_out) && $stable(m_freed_frame))
        else $error("result changed while stalled");

endmodule

bind two_level_page_table_engine_core tlpte_checker u_tlpte_checker (.*);
